// ===== sv/ict_pkg.sv =====
`timescale 1ns / 1ps

package ict_pkg;

  // Token kinds
  localparam logic [3:0] TK_SECT_OPEN = 4'd0;
  localparam logic [3:0] TK_SECT_CHAR = 4'd1;
  localparam logic [3:0] TK_SECT_END  = 4'd2;
  localparam logic [3:0] TK_KEY_CHAR  = 4'd3;
  localparam logic [3:0] TK_KEY_END   = 4'd4;
  localparam logic [3:0] TK_VAL_CHAR  = 4'd5;
  localparam logic [3:0] TK_VAL_END   = 4'd6;
  localparam logic [3:0] TK_EOF       = 4'd7;
  localparam logic [3:0] TK_ERROR     = 4'd8;

  // Error codes
  localparam logic [1:0] ERR_UNEXPECTED   = 2'd0;
  localparam logic [1:0] ERR_PREMATURE    = 2'd1;
  localparam logic [1:0] ERR_EOL_IN_QUOTE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_SECT_OPEN  = 3'd0;
  localparam logic [2:0] CFG_SECT_CLOSE = 3'd1;
  localparam logic [2:0] CFG_COMMENT    = 3'd2;
  localparam logic [2:0] CFG_ASSIGN     = 3'd3;
  localparam logic [2:0] CFG_QUOTE      = 3'd4;
  localparam logic [2:0] CFG_ESCAPE     = 3'd5;

  localparam logic [7:0] RST_SECT_OPEN  = 8'h5B;  // [
  localparam logic [7:0] RST_SECT_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] RST_COMMENT    = 8'h3B;  // ;
  localparam logic [7:0] RST_ASSIGN     = 8'h3D;  // =
  localparam logic [7:0] RST_QUOTE      = 8'h22;  // "
  localparam logic [7:0] RST_ESCAPE     = 8'h5C;  // backslash

  localparam logic [7:0]  CH_NL    = 8'h0A;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  character;
    logic [1:0]  error_code;
    logic [23:0] line_number;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [7:0] sect_open;
    logic [7:0] sect_close;
    logic [7:0] comment;
    logic [7:0] assign_ch;
    logic [7:0] quote;
    logic [7:0] escape;
  } cfg_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, 8'h2D};
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    case (c)
      8'h61, 8'h41: r = 8'h07;  // a
      8'h62, 8'h42: r = 8'h08;  // b
      8'h66, 8'h46: r = 8'h0C;  // f
      8'h6E, 8'h4E: r = 8'h0A;  // n
      8'h72, 8'h52: r = 8'h0D;  // r
      8'h74, 8'h54: r = 8'h09;  // t
      8'h76, 8'h56: r = 8'h0B;  // v
      default:      r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ini_config_tokenizer_top.sv =====
`timescale 1ns / 1ps

// INI tokenizer: one text byte per input word, tokens out one per word.
// Input channel (in_valid/in_stall/in_data): text_byte plus end_of_file; a
//   zero byte also counts as end of file. End of file rearms the parser.
// Output channel (out_valid/out_stall/out_data): one token per word, with
//   the line number and last_of_run set on the final token of a byte.
// Config port (cfg_we/cfg_index/cfg_data): six 8-bit delimiter registers,
//   written by the user only while the block is idle (not enforced).
// Datapath: a byte lands in the input register on acceptance, is parsed
//   from there straight into a 4-word result queue when two slots are
//   free, and its first token reaches out_valid from the queue head.
// Throughput: one byte per cycle unless the parse step waits. A byte yields
//   0, 1 or 2 tokens; the queue drains one token per cycle unless out_stall
//   is high, so the parse step waits only when fewer than two queue slots
//   are free. The input stalls while the parse step waits on a full register.
// Reset: delimiters go to [ ] ; = " and backslash, mode to top level,
//   line counter to 1, queue empty.
// Receiver stall: the head token holds; the queue fills, then the input
//   register, then in_stall rises. Nothing is dropped.
// After an error the parser ignores bytes until an end-of-file word.
module ini_config_tokenizer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ict_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ict_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import ict_pkg::*;

  typedef enum logic [3:0] {
    M_TOP, M_COMMENT, M_SECTION, M_KEY, M_AFTER_KEY,
    M_PRE_VALUE, M_RAW, M_QUOTED, M_ESCAPED, M_HALT
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       again;   // byte is handled again in the new mode
    logic       push;
    logic [3:0] kind;
    logic [7:0] ch;
    logic [1:0] err;
    logic       bump;    // line counter advances before the push
  } step_t;

  // One mode's handling of one byte
  function automatic step_t handle(input mode_t m, input logic [7:0] c, input cfg_t k);
    step_t s;
    s = '{mode: m, again: 1'b0, push: 1'b0, kind: TK_EOF, ch: 8'h00,
          err: ERR_UNEXPECTED, bump: 1'b0};
    case (m)
      M_TOP: begin
        if (c == k.sect_open) begin
          s.push = 1'b1; s.kind = TK_SECT_OPEN; s.mode = M_SECTION;
        end else if (c == k.comment) begin
          s.mode = M_COMMENT;
        end else if (c == CH_NL) begin
          s.bump = 1'b1;
        end else if (is_name_char(c)) begin
          s.mode = M_KEY; s.again = 1'b1;
        end else if (!is_space(c)) begin
          s.push = 1'b1; s.kind = TK_ERROR; s.mode = M_HALT;
        end
      end
      M_COMMENT: begin
        if (c == CH_NL) begin
          s.mode = M_TOP; s.again = 1'b1;
        end
      end
      M_SECTION: begin
        if (c == k.sect_close) begin
          s.push = 1'b1; s.kind = TK_SECT_END; s.mode = M_TOP;
        end else if (c == k.comment || c == CH_NL) begin
          s.push = 1'b1; s.kind = TK_ERROR; s.mode = M_HALT;
        end else if (is_name_char(c) || is_space(c)) begin
          s.push = 1'b1; s.kind = TK_SECT_CHAR; s.ch = c;
        end else begin
          s.push = 1'b1; s.kind = TK_ERROR; s.mode = M_HALT;
        end
      end
      M_KEY: begin
        if (c == k.assign_ch) begin
          s.push = 1'b1; s.kind = TK_KEY_END; s.mode = M_PRE_VALUE;
        end else if (c == k.comment) begin
          s.push = 1'b1; s.kind = TK_ERROR; s.mode = M_HALT;
        end else if (c == CH_NL) begin
          s.bump = 1'b1; s.push = 1'b1; s.kind = TK_KEY_END; s.mode = M_AFTER_KEY;
        end else if (is_space(c)) begin
          s.push = 1'b1; s.kind = TK_KEY_END; s.mode = M_AFTER_KEY;
        end else if (is_name_char(c)) begin
          s.push = 1'b1; s.kind = TK_KEY_CHAR; s.ch = c;
        end else begin
          s.push = 1'b1; s.kind = TK_ERROR; s.mode = M_HALT;
        end
      end
      M_AFTER_KEY: begin
        if (c == k.assign_ch) begin
          s.mode = M_PRE_VALUE;
        end else if (c == CH_NL) begin
          s.bump = 1'b1;
        end else if (!is_space(c)) begin
          s.push = 1'b1; s.kind = TK_ERROR; s.mode = M_HALT;
        end
      end
      M_PRE_VALUE: begin
        if (c == k.comment) begin
          s.push = 1'b1; s.kind = TK_ERROR; s.mode = M_HALT;
        end else if (c == CH_NL) begin
          s.bump = 1'b1;
        end else if (is_space(c)) begin
          s.mode = M_PRE_VALUE;
        end else if (c == k.quote) begin
          s.mode = M_QUOTED;
        end else begin
          s.push = 1'b1; s.kind = TK_VAL_CHAR; s.ch = c; s.mode = M_RAW;
        end
      end
      M_RAW: begin
        if (c == CH_NL || is_space(c) || c == k.comment) begin
          s.push = 1'b1; s.kind = TK_VAL_END; s.mode = M_TOP; s.again = 1'b1;
        end else begin
          s.push = 1'b1; s.kind = TK_VAL_CHAR; s.ch = c;
        end
      end
      M_QUOTED: begin
        if (c == CH_NL) begin
          s.push = 1'b1; s.kind = TK_ERROR; s.err = ERR_EOL_IN_QUOTE; s.mode = M_HALT;
        end else if (c == k.escape) begin
          s.mode = M_ESCAPED;
        end else if (c == k.quote) begin
          s.push = 1'b1; s.kind = TK_VAL_END; s.mode = M_TOP;
        end else begin
          s.push = 1'b1; s.kind = TK_VAL_CHAR; s.ch = c;
        end
      end
      M_ESCAPED: begin
        if (c == CH_NL) begin
          s.push = 1'b1; s.kind = TK_ERROR; s.err = ERR_EOL_IN_QUOTE; s.mode = M_HALT;
        end else begin
          s.push = 1'b1; s.kind = TK_VAL_CHAR; s.ch = unescape(c); s.mode = M_QUOTED;
        end
      end
      default: begin
        s.mode = m;   // halted: byte dropped
      end
    endcase
    return s;
  endfunction

  // Registers
  cfg_t       cfg_r;
  mode_t      mode_r, mode_nxt;
  logic [23:0] line_r, line_nxt;
  logic       item_v_r;
  in_word_t   item_r;
  out_word_t  q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r, count_nxt;

  // Parse step
  out_word_t  res0, res1;
  logic [1:0] nres;
  logic       is_eof;
  logic       advance, pop;
  logic [QAW:0] count_after_pop;

  always_comb begin
    step_t      st;
    mode_t      m;
    logic [23:0] ln;
    logic       active;
    res0 = '0;
    res1 = '0;
    nres = 2'd0;
    m = mode_r;
    ln = line_r;
    active = 1'b0;
    st = '0;
    is_eof = item_r.end_of_file || (item_r.text_byte == 8'h00);
    if (is_eof) begin
      case (mode_r)
        M_TOP, M_COMMENT, M_HALT: begin
          nres = 2'd1;
        end
        M_RAW: begin
          res0.token_kind = TK_VAL_END;
          res0.line_number = line_r;
          nres = 2'd2;
        end
        default: begin
          res0.token_kind = TK_ERROR;
          res0.error_code = ERR_PREMATURE;
          res0.line_number = line_r;
          nres = 2'd2;
        end
      endcase
      if (nres == 2'd1) begin
        res0.token_kind = TK_EOF;
        res0.line_number = line_r;
      end else begin
        res1.token_kind = TK_EOF;
        res1.line_number = line_r;
      end
      m = M_TOP;
      ln = 24'd1;
    end else begin
      active = (mode_r != M_HALT);
      // a byte passes through at most two modes (raw then top, comment then top, or top then key)
      for (int i = 0; i < 3; i++) begin
        if (active) begin
          st = handle(m, item_r.text_byte, cfg_r);
          if (st.bump && ln != LINE_MAX) begin
            ln = ln + 24'd1;
          end
          if (st.push) begin
            if (nres == 2'd0) begin
              res0.token_kind = st.kind;
              res0.character = st.ch;
              res0.error_code = st.err;
              res0.line_number = ln;
            end else begin
              res1.token_kind = st.kind;
              res1.character = st.ch;
              res1.error_code = st.err;
              res1.line_number = ln;
            end
            nres = nres + 2'd1;
          end
          m = st.mode;
          active = st.again;
        end
      end
    end
    res0.last_of_run = (nres == 2'd1);
    res1.last_of_run = (nres == 2'd2);
    mode_nxt = m;
    line_nxt = ln;
  end

  assign out_valid = (count_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign count_after_pop = count_r - {{QAW{1'b0}}, pop};
  // parse only when two slots are free after this cycle's pop
  assign advance   = item_v_r && (count_after_pop <= (QAW + 1)'(QDEPTH - 2));
  assign in_stall  = item_v_r && !advance;
  assign count_nxt = count_after_pop + (advance ? {{(QAW - 1){1'b0}}, nres} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= '{sect_open: RST_SECT_OPEN, sect_close: RST_SECT_CLOSE,
                    comment: RST_COMMENT, assign_ch: RST_ASSIGN,
                    quote: RST_QUOTE, escape: RST_ESCAPE};
      mode_r   <= M_TOP;
      line_r   <= 24'd1;
      item_v_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SECT_OPEN:  cfg_r.sect_open  <= cfg_data;
          CFG_SECT_CLOSE: cfg_r.sect_close <= cfg_data;
          CFG_COMMENT:    cfg_r.comment    <= cfg_data;
          CFG_ASSIGN:     cfg_r.assign_ch  <= cfg_data;
          CFG_QUOTE:      cfg_r.quote      <= cfg_data;
          CFG_ESCAPE:     cfg_r.escape     <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        mode_r   <= mode_nxt;
        line_r   <= line_nxt;
        wr_ptr_r <= wr_ptr_r + QAW'(nres);
      end
      if (in_valid && !in_stall) begin
        item_v_r <= 1'b1;
      end else if (advance) begin
        item_v_r <= 1'b0;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Payload: input register and result queue
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    if (advance && nres != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (advance && nres == 2'd2) begin
      q_r[wr_ptr_r + QAW'(1)] <= res1;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW + 1)'(QDEPTH))
    else $error("result queue overflow");

  a_eof_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_eof) |=> (mode_r == M_TOP && line_r == 24'd1))
    else $error("end of file did not rearm parser");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !is_eof && mode_r == M_HALT) |-> (nres == 2'd0))
    else $error("halted parser produced a token");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 24'd0)
    else $error("line counter reached zero");

  a_two_tokens_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && nres == 2'd2) |-> (res1.last_of_run && !res0.last_of_run))
    else $error("last_of_run misplaced");

endmodule

// ===== tb/ini_config_tokenizer_top_test.sv =====
`timescale 1ns / 1ps

module ini_config_tokenizer_top_test;
  import ict_pkg::*;

  // Generous bound: about 800 words, two tokens each, long stalls on both sides.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 6;

  // Token stream tracker: mirrors the parse mode, line counter and delimiters,
  // and keeps the tokens still owed by the block, oldest first.
  class token_scoreboard;
    typedef enum logic [3:0] {
      PM_TOP, PM_COMMENT, PM_SECTION, PM_KEY, PM_AFTER_KEY,
      PM_PRE_VALUE, PM_RAW, PM_QUOTED, PM_ESCAPED, PM_HALT
    } parse_mode_t;

    localparam logic [1:0] NO_ERR = 2'd0;

    cfg_t        delim;
    parse_mode_t mode;
    logic [23:0] line_no;
    out_word_t   owed_tokens[$];
    out_word_t   word_tokens[$];
    int          errors;
    int          tokens_seen;

    function new();
      errors = 0;
      tokens_seen = 0;
      delim.sect_open  = RST_SECT_OPEN;
      delim.sect_close = RST_SECT_CLOSE;
      delim.comment    = RST_COMMENT;
      delim.assign_ch  = RST_ASSIGN;
      delim.quote      = RST_QUOTE;
      delim.escape     = RST_ESCAPE;
      mode = PM_TOP;
      line_no = 24'd1;
    endfunction

    function void write_delim(logic [2:0] idx, logic [7:0] v);
      case (idx)
        CFG_SECT_OPEN:  delim.sect_open = v;
        CFG_SECT_CLOSE: delim.sect_close = v;
        CFG_COMMENT:    delim.comment = v;
        CFG_ASSIGN:     delim.assign_ch = v;
        CFG_QUOTE:      delim.quote = v;
        CFG_ESCAPE:     delim.escape = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_tokens.size();
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit is_ident(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F || c == 8'h2D;
    endfunction

    function logic [7:0] escape_value(logic [7:0] c);
      logic [7:0] lc;
      lc = c | 8'h20;  // case fold; only letters land on these codes
      case (lc)
        8'h61: return 8'h07;
        8'h62: return 8'h08;
        8'h66: return 8'h0C;
        8'h6E: return 8'h0A;
        8'h72: return 8'h0D;
        8'h74: return 8'h09;
        8'h76: return 8'h0B;
        default: return c;
      endcase
    endfunction

    // At most two tokens per word; extras are dropped.
    function void emit(logic [3:0] kind, logic [7:0] ch, logic [1:0] err);
      out_word_t t;
      if (word_tokens.size() < 2) begin
        t.token_kind  = kind;
        t.character   = ch;
        t.error_code  = err;
        t.line_number = line_no;
        t.last_of_run = 1'b0;
        word_tokens.push_back(t);
      end
    endfunction

    function void stop_on_error(logic [1:0] err);
      emit(TK_ERROR, 8'h00, err);
      mode = PM_HALT;
    endfunction

    function void next_line();
      if (line_no != LINE_MAX) line_no++;
    endfunction

    // One byte in the current mode; returns 1 when the byte must be seen again.
    function bit consume(logic [7:0] c);
      case (mode)
        PM_TOP: begin
          if (c == delim.sect_open) begin
            emit(TK_SECT_OPEN, 8'h00, NO_ERR);
            mode = PM_SECTION;
          end else if (c == delim.comment) begin
            mode = PM_COMMENT;
          end else if (c == CH_NL) begin
            next_line();
          end else if (is_ident(c)) begin
            mode = PM_KEY;
            return 1'b1;
          end else if (!is_blank(c)) begin
            stop_on_error(ERR_UNEXPECTED);
          end
        end
        PM_COMMENT: begin
          if (c == CH_NL) begin
            mode = PM_TOP;
            return 1'b1;
          end
        end
        PM_SECTION: begin
          if (c == delim.sect_close) begin
            emit(TK_SECT_END, 8'h00, NO_ERR);
            mode = PM_TOP;
          end else if (c == delim.comment || c == CH_NL) begin
            stop_on_error(ERR_UNEXPECTED);
          end else if (is_ident(c) || is_blank(c)) begin
            emit(TK_SECT_CHAR, c, NO_ERR);
          end else begin
            stop_on_error(ERR_UNEXPECTED);
          end
        end
        PM_KEY: begin
          if (c == delim.assign_ch) begin
            emit(TK_KEY_END, 8'h00, NO_ERR);
            mode = PM_PRE_VALUE;
          end else if (c == delim.comment) begin
            stop_on_error(ERR_UNEXPECTED);
          end else if (c == CH_NL) begin
            next_line();
            emit(TK_KEY_END, 8'h00, NO_ERR);
            mode = PM_AFTER_KEY;
          end else if (is_blank(c)) begin
            emit(TK_KEY_END, 8'h00, NO_ERR);
            mode = PM_AFTER_KEY;
          end else if (is_ident(c)) begin
            emit(TK_KEY_CHAR, c, NO_ERR);
          end else begin
            stop_on_error(ERR_UNEXPECTED);
          end
        end
        PM_AFTER_KEY: begin
          if (c == delim.assign_ch) mode = PM_PRE_VALUE;
          else if (c == CH_NL) next_line();
          else if (!is_blank(c)) stop_on_error(ERR_UNEXPECTED);
        end
        PM_PRE_VALUE: begin
          if (c == delim.comment) begin
            stop_on_error(ERR_UNEXPECTED);
          end else if (c == CH_NL) begin
            next_line();
          end else if (is_blank(c)) begin
          end else if (c == delim.quote) begin
            mode = PM_QUOTED;
          end else begin
            emit(TK_VAL_CHAR, c, NO_ERR);
            mode = PM_RAW;
          end
        end
        PM_RAW: begin
          if (c == CH_NL || is_blank(c) || c == delim.comment) begin
            emit(TK_VAL_END, 8'h00, NO_ERR);
            mode = PM_TOP;
            return 1'b1;
          end
          emit(TK_VAL_CHAR, c, NO_ERR);
        end
        PM_QUOTED: begin
          if (c == CH_NL) begin
            stop_on_error(ERR_EOL_IN_QUOTE);
          end else if (c == delim.escape) begin
            mode = PM_ESCAPED;
          end else if (c == delim.quote) begin
            emit(TK_VAL_END, 8'h00, NO_ERR);
            mode = PM_TOP;
          end else begin
            emit(TK_VAL_CHAR, c, NO_ERR);
          end
        end
        PM_ESCAPED: begin
          if (c == CH_NL) begin
            stop_on_error(ERR_EOL_IN_QUOTE);
          end else begin
            emit(TK_VAL_CHAR, escape_value(c), NO_ERR);
            mode = PM_QUOTED;
          end
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    // Called for every accepted input word.
    function void note_word(in_word_t w);
      logic [7:0] c;
      int spins;
      out_word_t t;
      c = w.text_byte;
      word_tokens.delete();
      if (w.end_of_file || c == 8'h00) begin
        case (mode)
          PM_TOP, PM_COMMENT, PM_HALT: ;
          PM_RAW:  emit(TK_VAL_END, 8'h00, NO_ERR);
          default: emit(TK_ERROR, 8'h00, ERR_PREMATURE);
        endcase
        emit(TK_EOF, 8'h00, NO_ERR);
        mode = PM_TOP;
        line_no = 24'd1;
      end else if (mode != PM_HALT) begin
        spins = 0;
        while (consume(c) && spins < 3) spins++;
      end
      if (word_tokens.size() > 0) begin
        t = word_tokens.pop_back();
        t.last_of_run = 1'b1;
        word_tokens.push_back(t);
      end
      foreach (word_tokens[i]) owed_tokens.push_back(word_tokens[i]);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] token %0d: %s", $time, tokens_seen, msg);
    endtask

    // Called for every accepted output word.
    task check_token(out_word_t got);
      out_word_t want;
      tokens_seen++;
      if (owed_tokens.size() == 0) begin
        report($sformatf("kind %0d arrived with nothing owed", got.token_kind));
        return;
      end
      want = owed_tokens.pop_front();
      if (got.token_kind !== want.token_kind)
        report($sformatf("token_kind %0d, want %0d", got.token_kind, want.token_kind));
      if (got.character !== want.character)
        report($sformatf("character %h, want %h", got.character, want.character));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
      if (got.line_number !== want.line_number)
        report($sformatf("line_number %0d, want %0d", got.line_number, want.line_number));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
    endtask
  endclass

  // DUT hookup; every input starts at a known value.
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_SECT_OPEN;
  logic [7:0] cfg_data = 8'h00;

  token_scoreboard sb;
  int unsigned     cycle_count = 0;
  int              words_sent = 0;
  bit              idle_on = 1'b0;  // random gaps/stalls enabled
  bit              hold_req = 1'b0; // ask the receiver for one long hold-off
  int              stall_left = 0;
  int              hold_left = 0;

  ini_config_tokenizer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Mostly short idle runs, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_data);
      if (out_valid && !out_stall) sb.check_token(out_data);
    end
  end

  // Receiver: random stall runs, plus one long hold-off on request so the
  // result queue and input register fill and in_stall rises.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 99) < 20) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one word and hold it until accepted. Valid stays high afterwards
  // unless a gap is taken, so back-to-back words go one per cycle while in_stall is low.
  task automatic send_word(in_word_t w);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (idle_on && $urandom_range(0, 99) < 20) begin
      gap = idle_len();
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic put(logic [7:0] b);
    in_word_t w;
    w.text_byte = b;
    w.end_of_file = 1'b0;
    send_word(w);
  endtask

  task automatic put_eof(logic [7:0] b);
    in_word_t w;
    w.text_byte = b;
    w.end_of_file = 1'b1;
    send_word(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // Wait until every owed token is out, let the pipe settle. Sender idle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_delim(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_delims(logic [7:0] o, logic [7:0] c, logic [7:0] m,
                             logic [7:0] a, logic [7:0] q, logic [7:0] e);
    drain();
    set_reg(CFG_SECT_OPEN, o);
    set_reg(CFG_SECT_CLOSE, c);
    set_reg(CFG_COMMENT, m);
    set_reg(CFG_ASSIGN, a);
    set_reg(CFG_QUOTE, q);
    set_reg(CFG_ESCAPE, e);
  endtask

  function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  // Character pickers for well-formed text under the current delimiters.
  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 3))
      0: return rand_byte(8'h30, 8'h39);
      1: return rand_byte(8'h41, 8'h5A);
      2: return rand_byte(8'h61, 8'h7A);
      default: return $urandom_range(0, 1) ? 8'h5F : 8'h2D;
    endcase
  endfunction

  function automatic logic [7:0] raw_char();
    logic [7:0] c;
    do c = rand_byte(8'h21, 8'hFF); while (c == sb.delim.comment);
    return c;
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    do c = rand_byte(1, 255);
    while (c == CH_NL || c == sb.delim.quote || c == sb.delim.escape);
    return c;
  endfunction

  function automatic logic [7:0] escape_target();
    string letters;
    letters = "abfnrtvABFNRTVxq";
    if ($urandom_range(0, 3) == 0) return rand_byte(1, 255);
    return letters[$urandom_range(0, letters.len() - 1)];
  endfunction

  // Key name, optional break (blank or newline), then the assignment.
  task automatic send_key();
    repeat ($urandom_range(1, 5)) put(name_char());
    case ($urandom_range(0, 5))
      0: put(8'h20);
      1: put(8'h09);
      2: begin
        put(CH_NL);
        put(8'h20);
      end
      default: ;
    endcase
    put(sb.delim.assign_ch);
  endtask

  task automatic send_quoted();
    put(sb.delim.quote);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        put(sb.delim.escape);
        put($urandom_range(0, 30) == 0 ? CH_NL : escape_target());
      end else if ($urandom_range(0, 40) == 0) begin
        put(CH_NL);  // newline inside quotes
      end else begin
        put(quoted_char());
      end
    end
    put(sb.delim.quote);
  endtask

  // One line of text: mostly well-formed entries with random content.
  task automatic send_line();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      put(sb.delim.sect_open);
      repeat ($urandom_range(0, 5)) put($urandom_range(0, 4) == 0 ? 8'h20 : name_char());
      put(sb.delim.sect_close);
    end else if (pick < 70) begin
      send_key();
      if ($urandom_range(0, 2) == 0) put(8'h20);
      case ($urandom_range(0, 9))
        0: ;  // empty value, picked up from the next line
        1, 2, 3, 4: send_quoted();
        default: repeat ($urandom_range(1, 6)) put(raw_char());
      endcase
    end else if (pick < 80) begin
      put(sb.delim.comment);
      repeat ($urandom_range(0, 4)) put(rand_byte(8'h0B, 8'hFF));
    end else if (pick < 88) begin
      repeat ($urandom_range(0, 3)) put($urandom_range(0, 1) ? 8'h20 : 8'h0D);
    end else begin
      // noise: any byte, the end-of-file flag now and then
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 19) == 0) put_eof(rand_byte(0, 255));
        else put(rand_byte(0, 255));
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      put(8'h20);
      put(sb.delim.comment);
      put(name_char());
    end
    put(CH_NL);
  endtask

  // A few lines, then one of the ways a file can end.
  task automatic send_file();
    repeat ($urandom_range(1, 6)) send_line();
    case ($urandom_range(0, 9))
      0: put(8'h00);
      1, 2: begin  // cut short inside a quoted value
        send_key();
        put(sb.delim.quote);
        put(name_char());
        put_eof(rand_byte(0, 255));
      end
      3: begin  // cut short inside a raw value
        send_key();
        put(name_char());
        put_eof(rand_byte(0, 255));
      end
      default: put_eof(rand_byte(0, 255));
    endcase
  endtask

  task automatic run_files(int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) send_file();
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset delimiters, no idling.
    send_text("[_]\n");            // section open, name char, section end
    send_text("Z\t\n=\"\\T\"\n");  // key ended by tab, assign on next line, escape
    send_text("-=");
    put(8'h00);                    // zero byte as premature end
    send_text("9=");
    put(8'hFF);                    // raw value with a high byte
    put_eof(8'h5A);                // end of file inside raw value
    send_text("[\nx");             // newline in section header, then halted
    put_eof(8'h00);
    send_text("k=\"\n");           // newline inside quotes
    put_eof(8'hFF);

    idle_on = 1'b1;
    run_files(130);

    // Long receiver hold-off while the sender streams without gaps.
    idle_on = 1'b0;
    hold_req = 1'b1;
    run_files(30);
    idle_on = 1'b1;

    load_delims(8'h3C, 8'h3E, 8'h23, 8'h3A, 8'h27, 8'h5E);
    run_files(110);

    // All delimiters equal: the first test in each mode wins.
    load_delims(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_files(40);
    load_delims(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_files(30);

    // Comment on newline, assignment on a blank, quote on a high byte.
    load_delims(8'h01, 8'hFE, CH_NL, 8'h20, 8'h80, 8'h7F);
    run_files(50);

    load_delims(rand_byte(0, 255), rand_byte(0, 255), rand_byte(0, 255),
                rand_byte(0, 255), rand_byte(0, 255), rand_byte(0, 255));
    run_files(80);

    load_delims(RST_SECT_OPEN, RST_SECT_CLOSE, RST_COMMENT, RST_ASSIGN, RST_QUOTE,
                RST_ESCAPE);
    idle_on = 1'b0;
    run_files(60);
    idle_on = 1'b1;
    run_files(45);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
